>>> hw/rtl/swg_pkg.sv
// ----------------------------------------------------------------------------
// swg_pkg: shared definitions for the swipe gesture recogniser
// Event codes, heading codes, register indices, reset values and the result
// record passed from the step logic to the output register.
// ----------------------------------------------------------------------------
package swg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  localparam int OP_BITS      = 2;
  localparam int HEAD_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;

  // Event kinds.
  localparam logic [OP_BITS-1:0] OP_PRESS   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_MOVE    = 2'd2;
  localparam logic [OP_BITS-1:0] OP_UNUSED  = 2'd3;

  // Heading codes.
  localparam logic [HEAD_BITS-1:0] HEAD_NONE      = 4'd0;
  localparam logic [HEAD_BITS-1:0] HEAD_LEFT      = 4'd1;
  localparam logic [HEAD_BITS-1:0] HEAD_RIGHT     = 4'd2;
  localparam logic [HEAD_BITS-1:0] HEAD_UP        = 4'd3;
  localparam logic [HEAD_BITS-1:0] HEAD_DOWN      = 4'd4;
  localparam logic [HEAD_BITS-1:0] HEAD_UPLEFT    = 4'd5;
  localparam logic [HEAD_BITS-1:0] HEAD_UPRIGHT   = 4'd6;
  localparam logic [HEAD_BITS-1:0] HEAD_DOWNLEFT  = 4'd7;
  localparam logic [HEAD_BITS-1:0] HEAD_DOWNRIGHT = 4'd8;

  // Configuration register indices.
  localparam logic [CFG_IDX_BITS-1:0] REG_START_DIST   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_WINDOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINISH_DIST  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FINISH_WINDOW = 2'd3;

  // Register values after reset.
  localparam logic [31:0] START_DIST_RST    = 32'd9;
  localparam logic [31:0] START_WINDOW_RST  = 32'd100000;
  localparam logic [31:0] FINISH_DIST_RST   = 32'd70;
  localparam logic [31:0] FINISH_WINDOW_RST = 32'd150000;

  typedef struct packed {
    logic                 began;
    logic                 done;
    logic [HEAD_BITS-1:0] heading;
  } swg_result_t;

endpackage

>>> hw/rtl/swipe_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer: eight-way swipe detection on pointer events
// Input register, single-pass gesture step, result register.
// ----------------------------------------------------------------------------
// The block takes one pointer event per clock cycle while the output is not
// stalled and returns exactly one result per event: the event waits in the
// input register, then the gesture step updates the held state and loads the
// result register in the same cycle. The rate is set by that single step; a
// stalled output holds the result register and, once the input register is
// also full, stops further input transfers.
// Configuration writes must only be made while no event is in flight.
module swipe_gesture_recognizer #(
  parameter int COORD_BITS = swg_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = swg_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swg_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]             cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swg_pkg::OP_BITS-1:0]      op,
  input  logic [COORD_BITS-1:0]            pos_x,
  input  logic [COORD_BITS-1:0]            pos_y,
  input  logic [TIME_BITS-1:0]             stamp_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             swipe_began,
  output logic                             swipe_done,
  output logic [swg_pkg::HEAD_BITS-1:0]    heading
);
  import swg_pkg::*;

  // Configuration registers.
  logic [COORD_BITS-1:0] start_distance;
  logic [TIME_BITS-1:0]  start_window_us;
  logic [COORD_BITS-1:0] finish_distance;
  logic [TIME_BITS-1:0]  finish_window_us;

  // Input register.
  logic                  in_full;
  logic [OP_BITS-1:0]    op_q;
  logic [COORD_BITS-1:0] pos_x_q;
  logic [COORD_BITS-1:0] pos_y_q;
  logic [TIME_BITS-1:0]  stamp_q;
  logic                  advance;

  // Gesture state.
  logic                  pressed;
  logic [COORD_BITS-1:0] anchor_x;
  logic [COORD_BITS-1:0] anchor_y;
  logic [TIME_BITS-1:0]  anchor_time;
  logic                  began_flag;
  logic                  done_flag;
  logic [TIME_BITS-1:0]  began_time;
  logic [HEAD_BITS-1:0]  held_heading;

  logic                  pressed_next;
  logic [COORD_BITS-1:0] anchor_x_next;
  logic [COORD_BITS-1:0] anchor_y_next;
  logic [TIME_BITS-1:0]  anchor_time_next;
  logic                  began_flag_next;
  logic                  done_flag_next;
  logic [TIME_BITS-1:0]  began_time_next;
  logic [HEAD_BITS-1:0]  held_heading_next;

  swg_result_t           step_result;
  swg_result_t           result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_distance   <= COORD_BITS'(START_DIST_RST);
      start_window_us  <= TIME_BITS'(START_WINDOW_RST);
      finish_distance  <= COORD_BITS'(FINISH_DIST_RST);
      finish_window_us <= TIME_BITS'(FINISH_WINDOW_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_DIST:    start_distance   <= cfg_data[COORD_BITS-1:0];
        REG_START_WINDOW:  start_window_us  <= cfg_data;
        REG_FINISH_DIST:   finish_distance  <= cfg_data[COORD_BITS-1:0];
        REG_FINISH_WINDOW: finish_window_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The event in the input register moves on whenever the result register
  // is empty or is being emptied by a transfer in this cycle.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= op;
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      stamp_q <= stamp_us;
    end
  end

  swg_step #(
    .COORD_BITS(COORD_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .op               (op_q),
    .pos_x            (pos_x_q),
    .pos_y            (pos_y_q),
    .stamp_us         (stamp_q),
    .start_distance   (start_distance),
    .start_window_us  (start_window_us),
    .finish_distance  (finish_distance),
    .finish_window_us (finish_window_us),
    .pressed          (pressed),
    .anchor_x         (anchor_x),
    .anchor_y         (anchor_y),
    .anchor_time      (anchor_time),
    .began_flag       (began_flag),
    .done_flag        (done_flag),
    .began_time       (began_time),
    .held_heading     (held_heading),
    .pressed_next     (pressed_next),
    .anchor_x_next    (anchor_x_next),
    .anchor_y_next    (anchor_y_next),
    .anchor_time_next (anchor_time_next),
    .began_flag_next  (began_flag_next),
    .done_flag_next   (done_flag_next),
    .began_time_next  (began_time_next),
    .held_heading_next(held_heading_next),
    .result           (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed      <= 1'b0;
      anchor_x     <= '0;
      anchor_y     <= '0;
      anchor_time  <= '0;
      began_flag   <= 1'b0;
      done_flag    <= 1'b0;
      began_time   <= '0;
      held_heading <= HEAD_NONE;
    end else if (advance) begin
      pressed      <= pressed_next;
      anchor_x     <= anchor_x_next;
      anchor_y     <= anchor_y_next;
      anchor_time  <= anchor_time_next;
      began_flag   <= began_flag_next;
      done_flag    <= done_flag_next;
      began_time   <= began_time_next;
      held_heading <= held_heading_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign swipe_began = result_q.began;
  assign swipe_done  = result_q.done;
  assign heading     = result_q.heading;

  // A completed swipe must have been started first.
  assert property (@(posedge clk) disable iff (rst) done_flag |-> began_flag)
    else $error("swipe completed without having started");

  // A heading is held only while a swipe is under way.
  assert property (@(posedge clk) disable iff (rst)
    !began_flag |-> (held_heading == HEAD_NONE))
    else $error("heading held with no swipe started");

  // Releasing the pointer always ends the gesture.
  assert property (@(posedge clk) disable iff (rst) !pressed |-> !began_flag)
    else $error("swipe in progress while the pointer is released");

  // A reported start always carries a direction.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && swipe_began) |-> (heading != HEAD_NONE))
    else $error("swipe start reported without a heading");

endmodule

>>> hw/rtl/swg_step.sv
// ----------------------------------------------------------------------------
// swg_step: next-state logic for one pointer event
// Takes the held gesture state and one event and works out the state after
// the event together with the result record for it.
// ----------------------------------------------------------------------------
module swg_step #(
  parameter int COORD_BITS = swg_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = swg_pkg::TIME_BITS_DEF
) (
  input  logic [swg_pkg::OP_BITS-1:0]   op,
  input  logic [COORD_BITS-1:0]         pos_x,
  input  logic [COORD_BITS-1:0]         pos_y,
  input  logic [TIME_BITS-1:0]          stamp_us,
  input  logic [COORD_BITS-1:0]         start_distance,
  input  logic [TIME_BITS-1:0]          start_window_us,
  input  logic [COORD_BITS-1:0]         finish_distance,
  input  logic [TIME_BITS-1:0]          finish_window_us,
  input  logic                          pressed,
  input  logic [COORD_BITS-1:0]         anchor_x,
  input  logic [COORD_BITS-1:0]         anchor_y,
  input  logic [TIME_BITS-1:0]          anchor_time,
  input  logic                          began_flag,
  input  logic                          done_flag,
  input  logic [TIME_BITS-1:0]          began_time,
  input  logic [swg_pkg::HEAD_BITS-1:0] held_heading,
  output logic                          pressed_next,
  output logic [COORD_BITS-1:0]         anchor_x_next,
  output logic [COORD_BITS-1:0]         anchor_y_next,
  output logic [TIME_BITS-1:0]          anchor_time_next,
  output logic                          began_flag_next,
  output logic                          done_flag_next,
  output logic [TIME_BITS-1:0]          began_time_next,
  output logic [swg_pkg::HEAD_BITS-1:0] held_heading_next,
  output swg_pkg::swg_result_t          result
);
  import swg_pkg::*;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  on_x;
  logic                  on_y;
  logic                  fin_x;
  logic                  fin_y;
  logic                  go_right;
  logic                  go_down;
  logic [TIME_BITS-1:0]  start_elapsed;
  logic [TIME_BITS-1:0]  finish_elapsed;
  logic                  start_in_time;
  logic                  finish_late;
  logic [HEAD_BITS-1:0]  new_heading;

  assign go_right = anchor_x < pos_x;
  assign go_down  = anchor_y < pos_y;
  assign dx       = go_right ? pos_x - anchor_x : anchor_x - pos_x;
  assign dy       = go_down ? pos_y - anchor_y : anchor_y - pos_y;
  assign on_x     = dx >= start_distance;
  assign on_y     = dy >= start_distance;
  assign fin_x    = dx >= finish_distance;
  assign fin_y    = dy >= finish_distance;

  assign start_elapsed  = stamp_us - anchor_time;
  assign finish_elapsed = stamp_us - began_time;
  assign start_in_time  = start_elapsed < start_window_us;
  // A swipe begun on this very event is never late: only a swipe already held as begun is timed.
  assign finish_late    = began_flag && (finish_elapsed > finish_window_us);

  always_comb begin
    priority if (on_x && on_y) begin
      if (go_right) new_heading = go_down ? HEAD_DOWNRIGHT : HEAD_UPRIGHT;
      else          new_heading = go_down ? HEAD_DOWNLEFT : HEAD_UPLEFT;
    end else if (on_x) begin
      new_heading = go_right ? HEAD_RIGHT : HEAD_LEFT;
    end else if (on_y) begin
      new_heading = go_down ? HEAD_DOWN : HEAD_UP;
    end else begin
      new_heading = HEAD_NONE;
    end
  end

  always_comb begin
    logic began_now;
    logic go;
    pressed_next      = pressed;
    anchor_x_next     = anchor_x;
    anchor_y_next     = anchor_y;
    anchor_time_next  = anchor_time;
    began_flag_next   = began_flag;
    done_flag_next    = done_flag;
    began_time_next   = began_time;
    held_heading_next = held_heading;
    result.began      = 1'b0;
    result.done       = 1'b0;
    began_now         = 1'b0;
    go                = began_flag;
    unique case (op)
      OP_PRESS, OP_RELEASE: begin
        pressed_next      = (op == OP_PRESS);
        anchor_x_next     = (op == OP_PRESS) ? pos_x : '0;
        anchor_y_next     = (op == OP_PRESS) ? pos_y : '0;
        anchor_time_next  = stamp_us;
        began_flag_next   = 1'b0;
        done_flag_next    = 1'b0;
        began_time_next   = '0;
        held_heading_next = HEAD_NONE;
      end
      OP_MOVE: begin
        if (pressed && !done_flag) begin
          if (!began_flag && (on_x || on_y)) begin
            if (start_in_time) begin
              began_now         = 1'b1;
              began_flag_next   = 1'b1;
              began_time_next   = stamp_us;
              held_heading_next = new_heading;
            end else begin
              anchor_x_next    = pos_x;
              anchor_y_next    = pos_y;
              anchor_time_next = stamp_us;
            end
          end
          go = began_flag || began_now;
          result.began = began_now;
          if (go && (fin_x || fin_y)) begin
            if (finish_late) begin
              // Too slow: drop the gesture and restart from here.
              anchor_x_next     = pos_x;
              anchor_y_next     = pos_y;
              anchor_time_next  = stamp_us;
              began_time_next   = '0;
              began_flag_next   = 1'b0;
              done_flag_next    = 1'b0;
              held_heading_next = HEAD_NONE;
              result.began      = 1'b0;
            end else begin
              done_flag_next = 1'b1;
              result.done    = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    result.heading = held_heading_next;
  end

endmodule

>>> dv/swipe_gesture_recognizer_test.sv
// ----------------------------------------------------------------------------
// swipe_gesture_recognizer_test: self-checking bench for the swipe recogniser
// Pointer events are fed through a valid/ready driver. An in-bench gesture
// tracker predicts one result per accepted event, and a monitor compares
// every result transfer field by field. The run steps through several
// register settings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module swipe_gesture_recognizer_test;
  import swg_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int TIME_W      = TIME_BITS_DEF;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  stamp;
  } pointer_event_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_START_DIST;
  logic [TIME_W-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_BITS-1:0]      op = OP_PRESS;
  logic [COORD_W-1:0]      pos_x = '0;
  logic [COORD_W-1:0]      pos_y = '0;
  logic [TIME_W-1:0]       stamp_us = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    swipe_began;
  logic                    swipe_done;
  logic [HEAD_BITS-1:0]    heading;

  swipe_gesture_recognizer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .stamp_us   (stamp_us),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .swipe_began(swipe_began),
    .swipe_done (swipe_done),
    .heading    (heading)
  );

  always #6 clk = ~clk;

  // Register copies held by the tracker.
  logic [COORD_W-1:0] cur_start_dist    = START_DIST_RST[COORD_W-1:0];
  logic [TIME_W-1:0]  cur_start_window  = START_WINDOW_RST;
  logic [COORD_W-1:0] cur_finish_dist   = FINISH_DIST_RST[COORD_W-1:0];
  logic [TIME_W-1:0]  cur_finish_window = FINISH_WINDOW_RST;

  // Gesture state of the tracker.
  logic                 trk_pressed  = 1'b0;
  logic [COORD_W-1:0]   trk_anchor_x = '0;
  logic [COORD_W-1:0]   trk_anchor_y = '0;
  logic [TIME_W-1:0]    trk_anchor_t = '0;
  logic                 trk_began    = 1'b0;
  logic                 trk_done     = 1'b0;
  logic [TIME_W-1:0]    trk_began_t  = '0;
  logic [HEAD_BITS-1:0] trk_heading  = HEAD_NONE;

  pointer_event_t pending_events[$];
  swg_result_t    expected_results[$];
  pointer_event_t bus_event;
  swg_result_t    want_result;

  int unsigned send_idle_pct  = 16;
  int unsigned recv_stall_pct = 56;
  logic        hold_armed = 1'b0;
  logic        rx_hold = 1'b0;
  logic [TIME_W-1:0] wall_us = 32'hFFF0_0000;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned events_in = 0;
  int unsigned swipes_started = 0;
  int unsigned swipes_completed = 0;
  int unsigned swipes_abandoned = 0;

  function automatic void clear_gesture(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [TIME_W-1:0] t);
    trk_anchor_x = x;
    trk_anchor_y = y;
    trk_anchor_t = t;
    trk_began_t  = '0;
    trk_began    = 1'b0;
    trk_done     = 1'b0;
    trk_heading  = HEAD_NONE;
  endfunction

  // Advances the tracked gesture by one pointer event and returns the result
  // that the block must produce for it.
  function automatic swg_result_t gesture_step(input pointer_event_t ev);
    swg_result_t        res;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [TIME_W-1:0]  elapsed;
    logic               on_x;
    logic               on_y;
    logic               right;
    logic               down;
    logic               test_finish;
    res.began = 1'b0;
    res.done  = 1'b0;
    dx = (trk_anchor_x > ev.x) ? trk_anchor_x - ev.x : ev.x - trk_anchor_x;
    dy = (trk_anchor_y > ev.y) ? trk_anchor_y - ev.y : ev.y - trk_anchor_y;
    case (ev.op)
      OP_PRESS: begin
        trk_pressed = 1'b1;
        clear_gesture(ev.x, ev.y, ev.stamp);
      end
      OP_RELEASE: begin
        trk_pressed = 1'b0;
        clear_gesture('0, '0, ev.stamp);
      end
      OP_MOVE: begin
        if (trk_pressed && !trk_done) begin
          test_finish = 1'b1;
          if (!trk_began) begin
            on_x = dx >= cur_start_dist;
            on_y = dy >= cur_start_dist;
            if (on_x || on_y) begin
              elapsed = ev.stamp - trk_anchor_t;
              if (elapsed < cur_start_window) begin
                // A tie on an axis falls to left or up.
                right = trk_anchor_x < ev.x;
                down  = trk_anchor_y < ev.y;
                if (on_x && on_y)
                  trk_heading = right ? (down ? HEAD_DOWNRIGHT : HEAD_UPRIGHT)
                                      : (down ? HEAD_DOWNLEFT : HEAD_UPLEFT);
                else if (on_x)
                  trk_heading = right ? HEAD_RIGHT : HEAD_LEFT;
                else
                  trk_heading = down ? HEAD_DOWN : HEAD_UP;
                trk_began   = 1'b1;
                trk_began_t = ev.stamp;
                res.began   = 1'b1;
                swipes_started++;
              end else begin
                // Too slow to start: the segment restarts from here.
                trk_anchor_x = ev.x;
                trk_anchor_y = ev.y;
                trk_anchor_t = ev.stamp;
              end
            end
            test_finish = trk_began;
          end
          // The finish test uses the distances taken before any restart.
          if (test_finish && (dx >= cur_finish_dist || dy >= cur_finish_dist)) begin
            elapsed = ev.stamp - trk_began_t;
            if (elapsed > cur_finish_window) begin
              clear_gesture(ev.x, ev.y, ev.stamp);
              res.began = 1'b0;
              swipes_abandoned++;
            end else begin
              trk_done = 1'b1;
              res.done = 1'b1;
              swipes_completed++;
            end
          end
        end
      end
      default: ;
    endcase
    res.heading = trk_heading;
    return res;
  endfunction

  // Driver: on each transfer the tracker is stepped, then the next event is
  // offered unless this cycle is an idle one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(gesture_step(bus_event));
        events_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_event = pending_events.pop_front();
          in_valid <= 1'b1;
          op       <= bus_event.op;
          pos_x    <= bus_event.x;
          pos_y    <= bus_event.y;
          stamp_us <= bus_event.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: began %0d done %0d heading %0d",
                 swipe_began, swipe_done, heading);
          mismatches++;
        end else begin
          want_result = expected_results.pop_front();
          if (swipe_began !== want_result.began) begin
            $error("swipe_began: expected %0d, actual %0d", want_result.began, swipe_began);
            mismatches++;
          end
          if (swipe_done !== want_result.done) begin
            $error("swipe_done: expected %0d, actual %0d", want_result.done, swipe_done);
            mismatches++;
          end
          if (heading !== want_result.heading) begin
            $error("heading: expected %0d, actual %0d", want_result.heading, heading);
            mismatches++;
          end
        end
      end
      out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long output hold-off, so that the block fills up and stalls its input.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("swipe_gesture_recognizer: mismatch");
      $finish;
    end
  end

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  task automatic add_event(input logic [OP_BITS-1:0] kind, input int x, input int y,
                           input logic [TIME_W-1:0] t);
    pointer_event_t ev;
    ev.op    = kind;
    ev.x     = x[COORD_W-1:0];
    ev.y     = y[COORD_W-1:0];
    ev.stamp = t;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TIME_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_START_DIST:    cur_start_dist    = value[COORD_W-1:0];
      REG_START_WINDOW:  cur_start_window  = value;
      REG_FINISH_DIST:   cur_finish_dist   = value[COORD_W-1:0];
      REG_FINISH_WINDOW: cur_finish_window = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(input logic [TIME_W-1:0] s_dist, input logic [TIME_W-1:0] s_win,
                               input logic [TIME_W-1:0] f_dist, input logic [TIME_W-1:0] f_win);
    write_reg(REG_START_DIST, s_dist);
    write_reg(REG_START_WINDOW, s_win);
    write_reg(REG_FINISH_DIST, f_dist);
    write_reg(REG_FINISH_WINDOW, f_win);
    @(negedge clk);
  endtask

  task automatic random_registers();
    int unsigned s_dist;
    s_dist = $urandom_range(1, 40);
    set_registers(s_dist, $urandom_range(20, 2000), $urandom_range(s_dist, 300),
                  $urandom_range(50, 5000));
  endtask

  // Waits until every event has been transferred and every result checked.
  task automatic drain();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Mostly whole gestures (press, a run of moves along one heading, release)
  // scaled to the current registers, with some stray events mixed in.
  task automatic queue_gestures(input int count);
    int          n;
    int          x;
    int          y;
    int          dir_x;
    int          dir_y;
    int          step;
    int unsigned step_max;
    int unsigned t_span;
    n = 0;
    while (n < count) begin
      t_span = (cur_start_window > cur_finish_window) ? cur_start_window : cur_finish_window;
      if (t_span > 300000) t_span = 300000;
      t_span = t_span / 4 + 1;
      step_max = cur_start_dist + cur_finish_dist / 2 + 4;
      if ($urandom_range(99) < 15) begin
        add_event(OP_BITS'($urandom_range(0, 3)), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom);
        n++;
      end else begin
        if ($urandom_range(99) < 3)
          wall_us += $urandom;
        else
          wall_us += $urandom_range(0, t_span);
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
        add_event(OP_PRESS, x, y, wall_us);
        n++;
        dir_x = int'($urandom_range(0, 2)) - 1;
        dir_y = int'($urandom_range(0, 2)) - 1;
        if (dir_x == 0 && dir_y == 0) dir_x = 1;
        repeat ($urandom_range(1, 8)) begin
          step = $urandom_range(0, step_max);
          x = clamp_coord(x + dir_x * step + int'($urandom_range(0, 2)) - 1);
          step = $urandom_range(0, step_max);
          y = clamp_coord(y + dir_y * step + int'($urandom_range(0, 2)) - 1);
          if ($urandom_range(99) < 12)
            wall_us += $urandom_range(0, 5 * t_span);
          else
            wall_us += $urandom_range(0, t_span);
          add_event(OP_MOVE, x, y, wall_us);
          n++;
        end
        if ($urandom_range(99) < 70) begin
          wall_us += $urandom_range(0, t_span);
          add_event(OP_RELEASE, x, y, wall_us);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values: directed cases first.
    add_event(OP_MOVE, 100, 100, 5);
    add_event(OP_UNUSED, COORD_MAX, 0, 32'hFFFF_FFFF);
    add_event(OP_PRESS, 0, 0, 0);
    add_event(OP_MOVE, 9, 0, 10);
    add_event(OP_MOVE, 80, 0, 20);
    add_event(OP_MOVE, 0, 0, 30);
    add_event(OP_RELEASE, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
    // Start and finish on one move, across a timestamp wrap.
    add_event(OP_PRESS, COORD_MAX, COORD_MAX, 32'hFFFF_FFF0);
    add_event(OP_MOVE, 4000, 4000, 32'h0000_0010);
    // Start window missed by one: the anchor moves, then a start, then an abort.
    add_event(OP_PRESS, 2000, 2000, 1000);
    add_event(OP_MOVE, 2100, 2000, 101000);
    add_event(OP_MOVE, 2109, 2009, 101001);
    add_event(OP_MOVE, 2100, 2200, 251002);
    add_event(OP_MOVE, 2100, 2191, 251003);
    add_event(OP_MOVE, 2100, 2121, 401003);
    add_event(OP_PRESS, 500, 500, 7);
    add_event(OP_MOVE, 491, 500, 8);
    add_event(OP_PRESS, 500, 500, 9);
    add_event(OP_MOVE, 500, 509, 10);
    add_event(OP_PRESS, 500, 500, 11);
    add_event(OP_MOVE, 509, 491, 12);
    add_event(OP_PRESS, 500, 500, 13);
    add_event(OP_MOVE, 491, 509, 14);
    add_event(OP_UNUSED, 7, 7, 14);
    add_event(OP_RELEASE, 0, 0, 15);
    queue_gestures(380);
    drain();

    // Zero distances, widest start window and a zero finish window.
    set_registers(0, 32'hFFFF_FFFF, 0, 0);
    add_event(OP_PRESS, 1234, 2345, 77);
    add_event(OP_MOVE, 1234, 2345, 78);
    queue_gestures(250);
    drain();

    send_idle_pct  = 56;
    recv_stall_pct = 16;
    set_registers(COORD_MAX, 0, COORD_MAX, 32'hFFFF_FFFF);
    queue_gestures(150);
    drain();

    random_registers();
    queue_gestures(450);
    drain();

    // Back to reset values with the output held off while events keep coming.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_registers(START_DIST_RST, START_WINDOW_RST, FINISH_DIST_RST, FINISH_WINDOW_RST);
    hold_armed = 1'b1;
    queue_gestures(250);
    drain();

    random_registers();
    queue_gestures(420);
    drain();

    repeat (8) @(posedge clk);
    $display("Covered %0d pointer events over six register settings with idling and a long stall.",
             events_in);
    $display("Swipes started %0d, completed %0d, abandoned %0d.",
             swipes_started, swipes_completed, swipes_abandoned);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("swipe_gesture_recognizer: match");
    else
      $display("swipe_gesture_recognizer: mismatch");
    $finish;
  end

endmodule

>>> swipe_gesture_recognizer.f
hw/rtl/swg_pkg.sv
hw/rtl/swg_step.sv
hw/rtl/swipe_gesture_recognizer.sv
dv/swipe_gesture_recognizer_test.sv
